### design/crs_pkg.sv
package crs_pkg;

    // table geometry
    localparam int MAX_STOPS_DEF = 16;
    localparam int COUNT_W       = 5;
    localparam int INDEX_W       = 4;
    localparam int POS_W         = 32;
    localparam int CHAN_W        = 16;
    localparam int COLOR_W       = 4 * CHAN_W;

    // fraction divider and channel loop
    localparam int FRAC_W        = 16;
    localparam int DIV_CNT_W     = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'd15;
    localparam logic [1:0]           CH_LAST  = 2'd3;

    // item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_TAIL,
        S_SCAN,
        S_DIV,
        S_MUL,
        S_ACC,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        RD_HOLD,
        RD_ZERO,
        RD_LAST,
        RD_ONE,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_FAIL,
        EMIT_RD,
        EMIT_RES
    } t_emit;

    typedef struct packed {
        logic     wr_stop;
        logic     latch;
        t_rd_sel  rd_sel;
        logic     save_left;
        logic     div_start;
        logic     div_step;
        logic     mul;
        logic     acc;
        logic [1:0] ch;
        t_emit    emit;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic t_le;
        logic t_ge;
        logic t_eq;
    } t_sts;

endpackage

### design/crs_ctrl.sv
module crs_ctrl
    import crs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_kind,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    t_state                r_state, n_state;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [1:0]            r_ch, n_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ch    <= n_ch;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_kind == KIND_SAMPLE && !i_sts.count_zero) n_state = S_HEAD;
            end
            S_HEAD: n_state = i_sts.t_le ? S_IDLE : S_TAIL;
            S_TAIL: n_state = i_sts.t_ge ? S_IDLE : S_SCAN;
            S_SCAN: begin
                if (i_sts.t_le) n_state = i_sts.t_eq ? S_IDLE : S_DIV;
            end
            S_DIV: begin
                if (r_cnt == DIV_LAST) n_state = S_MUL;
            end
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = (r_ch == CH_LAST) ? S_EMIT : S_MUL;
            S_EMIT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // step and channel counters
    always_comb begin
        n_cnt = (r_state == S_DIV) ? DIV_CNT_W'(r_cnt + 1'b1) : '0;
        unique case (r_state)
            S_MUL:   n_ch = r_ch;
            S_ACC:   n_ch = 2'(r_ch + 1'b1);
            default: n_ch = '0;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd           = '0;
        o_cmd.rd_sel    = RD_HOLD;
        o_cmd.emit      = EMIT_NONE;
        o_cmd.ch        = r_ch;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_kind == KIND_LOAD) begin
                        o_cmd.wr_stop = 1'b1;
                    end else begin
                        o_cmd.latch = 1'b1;
                        if (i_sts.count_zero) o_cmd.emit = EMIT_FAIL;
                        else o_cmd.rd_sel = RD_ZERO;
                    end
                end
            end
            S_HEAD: begin
                if (i_sts.t_le) begin
                    o_cmd.emit = EMIT_RD;
                end else begin
                    o_cmd.save_left = 1'b1;
                    o_cmd.rd_sel    = RD_LAST;
                end
            end
            S_TAIL: begin
                if (i_sts.t_ge) o_cmd.emit = EMIT_RD;
                else o_cmd.rd_sel = RD_ONE;
            end
            S_SCAN: begin
                if (i_sts.t_le) begin
                    if (i_sts.t_eq) o_cmd.emit = EMIT_RD;
                    else o_cmd.div_start = 1'b1;
                end else begin
                    o_cmd.save_left = 1'b1;
                    o_cmd.rd_sel    = RD_NEXT;
                end
            end
            S_DIV:  o_cmd.div_step = 1'b1;
            S_MUL:  o_cmd.mul = 1'b1;
            S_ACC:  o_cmd.acc = 1'b1;
            S_EMIT: o_cmd.emit = EMIT_RES;
            default: o_cmd.emit = EMIT_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### design/crs_dpath.sv
module crs_dpath
    import crs_pkg::*;
#(
    parameter int MAX_STOPS = MAX_STOPS_DEF
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic                      i_cfg_wr_en,
    input  logic [COUNT_W-1:0]        i_cfg_wr_data,
    input  logic [INDEX_W-1:0]        i_stop_index,
    input  logic signed [POS_W-1:0]   i_stop_position,
    input  logic [CHAN_W-1:0]         i_stop_red,
    input  logic [CHAN_W-1:0]         i_stop_green,
    input  logic [CHAN_W-1:0]         i_stop_blue,
    input  logic [CHAN_W-1:0]         i_stop_alpha,
    input  logic signed [POS_W-1:0]   i_sample_time,
    output logic                      o_valid,
    output logic [CHAN_W-1:0]         o_out_red,
    output logic [CHAN_W-1:0]         o_out_green,
    output logic [CHAN_W-1:0]         o_out_blue,
    output logic [CHAN_W-1:0]         o_out_alpha,
    output logic                      o_failed
);

    localparam int AW = $clog2(MAX_STOPS);

    logic [POS_W-1:0]   mem_pos [MAX_STOPS];
    logic [COLOR_W-1:0] mem_col [MAX_STOPS];

    logic [COUNT_W-1:0]       r_stop_count;
    logic signed [POS_W-1:0]  r_t;
    logic [AW-1:0]            r_last, cnt_last;
    logic [AW-1:0]            r_idx, rd_addr;
    logic signed [POS_W-1:0]  r_rd_pos;
    logic [COLOR_W-1:0]       r_rd_col;
    logic signed [POS_W-1:0]  r_left_pos;
    logic [COLOR_W-1:0]       r_left_col;
    logic [COLOR_W-1:0]       r_right_col;

    logic [POS_W-1:0]         r_rem, r_den;
    logic [FRAC_W-1:0]        r_quo;
    logic [POS_W:0]           rem_sh;
    logic [POS_W:0]           rem_sub;

    logic signed [2*CHAN_W+1:0] r_prod;
    logic [CHAN_W-1:0]          a_ch, b_ch;
    logic signed [CHAN_W:0]     diff;
    logic signed [2*CHAN_W+1:0] sum;
    logic [COLOR_W-1:0]         r_res;

    logic                     r_out_valid;
    logic [COLOR_W-1:0]       r_out_col;
    logic                     r_out_fail;

    logic signed [POS_W:0]    num_full, den_full;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_stop_count <= i_cfg_wr_data;
        end
    end

    // last valid index, count clamped to table depth
    always_comb begin
        if (32'(r_stop_count) > MAX_STOPS) cnt_last = AW'(MAX_STOPS - 1);
        else cnt_last = AW'(32'(r_stop_count) - 32'd1);
    end

    // stop table
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_stop && 32'(i_stop_index) < MAX_STOPS) begin
            mem_pos[AW'(i_stop_index)] <= i_stop_position;
            mem_col[AW'(i_stop_index)] <= {i_stop_alpha, i_stop_blue, i_stop_green, i_stop_red};
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_LAST: rd_addr = r_last;
            RD_ONE:  rd_addr = AW'(1);
            RD_NEXT: rd_addr = AW'(r_idx + 1'b1);
            default: rd_addr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_pos <= mem_pos[rd_addr];
        r_rd_col <= mem_col[rd_addr];
        r_idx    <= rd_addr;
    end

    // sample context
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_t    <= i_sample_time;
            r_last <= cnt_last;
        end
        if (i_cmd.save_left) begin
            r_left_pos <= r_rd_pos;
            r_left_col <= r_rd_col;
        end
        if (i_cmd.div_start) r_right_col <= r_rd_col;
    end

    assign o_sts.count_zero = (r_stop_count == '0);
    assign o_sts.t_le       = (r_t <= r_rd_pos);
    assign o_sts.t_ge       = (r_t >= r_rd_pos);
    assign o_sts.t_eq       = (r_t == r_rd_pos);

    // restoring divider, one quotient bit a cycle; num < den so quotient fits
    assign num_full = {r_t[POS_W-1], r_t} - {r_left_pos[POS_W-1], r_left_pos};
    assign den_full = {r_rd_pos[POS_W-1], r_rd_pos} - {r_left_pos[POS_W-1], r_left_pos};
    assign rem_sh   = {r_rem, 1'b0};
    assign rem_sub  = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= num_full[POS_W-1:0];
            r_den <= den_full[POS_W-1:0];
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            if (rem_sh >= {1'b0, r_den}) begin
                r_rem <= rem_sub[POS_W-1:0];
                r_quo <= {r_quo[FRAC_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[POS_W-1:0];
                r_quo <= {r_quo[FRAC_W-2:0], 1'b0};
            end
        end
    end

    // lerp per channel: a + floor((b - a) * f / 2^16)
    assign a_ch = r_left_col[{i_cmd.ch, 4'b0} +: CHAN_W];
    assign b_ch = r_right_col[{i_cmd.ch, 4'b0} +: CHAN_W];
    assign diff = $signed({1'b0, b_ch}) - $signed({1'b0, a_ch});
    assign sum  = $signed({{(CHAN_W+2){1'b0}}, a_ch}) + (r_prod >>> FRAC_W);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) r_prod <= diff * $signed({1'b0, r_quo});
        if (i_cmd.acc) r_res[{i_cmd.ch, 4'b0} +: CHAN_W] <= sum[CHAN_W-1:0];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_cmd.emit != EMIT_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.emit)
            EMIT_FAIL: begin
                r_out_col  <= '0;
                r_out_fail <= 1'b1;
            end
            EMIT_RD: begin
                r_out_col  <= r_rd_col;
                r_out_fail <= 1'b0;
            end
            EMIT_RES: begin
                r_out_col  <= r_res;
                r_out_fail <= 1'b0;
            end
            default: begin
                r_out_col  <= r_out_col;
                r_out_fail <= r_out_fail;
            end
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_out_red   = r_out_col[CHAN_W-1:0];
    assign o_out_green = r_out_col[2*CHAN_W-1:CHAN_W];
    assign o_out_blue  = r_out_col[3*CHAN_W-1:2*CHAN_W];
    assign o_out_alpha = r_out_col[4*CHAN_W-1:3*CHAN_W];
    assign o_failed    = r_out_fail;

endmodule

### design/color_ramp_sample_unit.sv
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+------------------------------------------
// item      | in        | start && !busy        | i_kind, i_stop_index, i_stop_position,
//           |           |                       | i_stop_red/green/blue/alpha, i_sample_time
// result    | out       | o_valid (one cycle)   | o_out_red/green/blue/alpha, o_failed
// config    | in        | i_cfg_wr_en           | i_cfg_wr_data (stop_count)
//
// load and empty-table beats never raise busy; a sample beat ends at the first-stop
// check when at or below the first stop, at the last-stop check when at or above the
// last, and otherwise interpolates (one stop read a cycle in the scan, a divider load,
// 16 divider steps, then a multiply and an accumulate per channel on the single lerp multiplier)
// the result strobes in the cycle after the decision, the receiver cannot stall
// synchronous active-low reset clears controller, stop_count and o_valid only
module color_ramp_sample_unit
    import crs_pkg::*;
#(
    parameter int MAX_STOPS = MAX_STOPS_DEF
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // item channel
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_kind,
    input  logic [INDEX_W-1:0]      i_stop_index,
    input  logic signed [POS_W-1:0] i_stop_position,
    input  logic [CHAN_W-1:0]       i_stop_red,
    input  logic [CHAN_W-1:0]       i_stop_green,
    input  logic [CHAN_W-1:0]       i_stop_blue,
    input  logic [CHAN_W-1:0]       i_stop_alpha,
    input  logic signed [POS_W-1:0] i_sample_time,
    // config write
    input  logic                    i_cfg_wr_en,
    input  logic [COUNT_W-1:0]      i_cfg_wr_data,
    // result channel
    output logic                    o_valid,
    output logic [CHAN_W-1:0]       o_out_red,
    output logic [CHAN_W-1:0]       o_out_green,
    output logic [CHAN_W-1:0]       o_out_blue,
    output logic [CHAN_W-1:0]       o_out_alpha,
    output logic                    o_failed
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: end checks, stop scan, divider and lerp steps
    crs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // stop table, comparators, fraction divider, lerp and result register
    crs_dpath #(
        .MAX_STOPS (MAX_STOPS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_stop_index    (i_stop_index),
        .i_stop_position (i_stop_position),
        .i_stop_red      (i_stop_red),
        .i_stop_green    (i_stop_green),
        .i_stop_blue     (i_stop_blue),
        .i_stop_alpha    (i_stop_alpha),
        .i_sample_time   (i_sample_time),
        .o_valid         (o_valid),
        .o_out_red       (o_out_red),
        .o_out_green     (o_out_green),
        .o_out_blue      (o_out_blue),
        .o_out_alpha     (o_out_alpha),
        .o_failed        (o_failed)
    );

endmodule

### tb/color_ramp_sample_unit_tb.sv
module color_ramp_sample_unit_tb;
    import crs_pkg::*;

    localparam int MAX_STOPS     = MAX_STOPS_DEF;
    localparam int TOTAL_BEATS   = 1750;
    // settle wait covers the longest sample beat, with some margin
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REPORT_MAX    = 10;

    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam longint POS_LO = -64'sd2147483648;
    localparam longint POS_HI = 64'sd2147483647;

    // channel 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [3:0][CHAN_W-1:0] t_rgba;

    typedef struct packed {
        logic                    kind;
        logic [INDEX_W-1:0]      slot;
        logic signed [POS_W-1:0] pos;
        t_rgba                   rgba;
        logic signed [POS_W-1:0] sample_t;
    } t_ramp_beat;

    typedef struct packed {
        t_rgba rgba;
        logic  failed;
    } t_ramp_color;

    // dut hookup, every input known from time zero
    logic                    i_clk;
    logic                    i_rst_n         = 1'b0;
    logic                    start           = 1'b0;
    logic                    busy;
    logic                    i_kind          = KIND_LOAD;
    logic [INDEX_W-1:0]      i_stop_index    = '0;
    logic signed [POS_W-1:0] i_stop_position = '0;
    logic [CHAN_W-1:0]       i_stop_red      = '0;
    logic [CHAN_W-1:0]       i_stop_green    = '0;
    logic [CHAN_W-1:0]       i_stop_blue     = '0;
    logic [CHAN_W-1:0]       i_stop_alpha    = '0;
    logic signed [POS_W-1:0] i_sample_time   = '0;
    logic                    i_cfg_wr_en     = 1'b0;
    logic [COUNT_W-1:0]      i_cfg_wr_data   = '0;
    logic                    o_valid;
    logic [CHAN_W-1:0]       o_out_red;
    logic [CHAN_W-1:0]       o_out_green;
    logic [CHAN_W-1:0]       o_out_blue;
    logic [CHAN_W-1:0]       o_out_alpha;
    logic                    o_failed;

    color_ramp_sample_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_stop_index    (i_stop_index),
        .i_stop_position (i_stop_position),
        .i_stop_red      (i_stop_red),
        .i_stop_green    (i_stop_green),
        .i_stop_blue     (i_stop_blue),
        .i_stop_alpha    (i_stop_alpha),
        .i_sample_time   (i_sample_time),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_valid         (o_valid),
        .o_out_red       (o_out_red),
        .o_out_green     (o_out_green),
        .o_out_blue      (o_out_blue),
        .o_out_alpha     (o_out_alpha),
        .o_failed        (o_failed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // beats waiting to be driven, and colors waiting to come out
    t_ramp_beat  beat_q [$];
    t_ramp_color color_expect_q [$];

    // predictor copy of the unit: stop table plus stop_count
    logic signed [POS_W-1:0] ramp_pos  [MAX_STOPS];
    t_rgba                   ramp_rgba [MAX_STOPS];
    logic [COUNT_W-1:0]      ramp_count = '0;

    // stimulus side view of the table, used to aim sample times
    logic signed [POS_W-1:0] plan_pos     [MAX_STOPS];
    bit                      plan_written [MAX_STOPS];

    t_ramp_beat cur_beat;
    int         idle_pct   = 0;
    int         gap_left   = 0;
    bit         gap_done   = 1'b0;
    int         beats_made = 0;
    int         mismatches = 0;
    int         colors_seen = 0;
    int         cycles     = 0;

    // evaluate the gradient at one time, truncating fraction and lerp
    function automatic t_ramp_color sample_ramp(input logic signed [POS_W-1:0] tq);
        t_ramp_color res;
        int          n;
        longint      lp, rp, num, den, frac, a, b;
        res = '0;
        n = (ramp_count > MAX_STOPS) ? MAX_STOPS : int'(ramp_count);
        if (n == 0) begin
            // empty table flags failure, colors stay zero
            res.failed = 1'b1;
            return res;
        end
        if (tq <= ramp_pos[0]) begin
            res.rgba = ramp_rgba[0];
            return res;
        end
        if (tq >= ramp_pos[n-1]) begin
            res.rgba = ramp_rgba[n-1];
            return res;
        end
        // first stop at or above tq is the right neighbor
        for (int i = 1; i < n; i++) begin
            if (tq <= ramp_pos[i]) begin
                if (tq == ramp_pos[i]) begin
                    res.rgba = ramp_rgba[i];
                    return res;
                end
                lp   = ramp_pos[i-1];
                rp   = ramp_pos[i];
                num  = longint'(tq) - lp;
                den  = rp - lp;
                frac = (num <<< 16) / den;
                if (frac > 65535)
                    frac = 65535;
                for (int c = 0; c < 4; c++) begin
                    a = ramp_rgba[i-1][c];
                    b = ramp_rgba[i][c];
                    res.rgba[c] = CHAN_W'((a * (65536 - frac) + b * frac) >>> 16);
                end
                return res;
            end
        end
        res.rgba = ramp_rgba[n-1];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // driver: presents queued beats, idles in random bursts, and feeds
    // the predictor with each beat at the edge that takes it
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (start && !busy) begin
            if (cur_beat.kind == KIND_LOAD) begin
                if (cur_beat.slot < MAX_STOPS) begin
                    ramp_pos[cur_beat.slot]  = cur_beat.pos;
                    ramp_rgba[cur_beat.slot] = cur_beat.rgba;
                end
            end else begin
                color_expect_q.push_back(sample_ramp(cur_beat.sample_t));
            end
        end
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // unit still working, hold the beat on the ports
        end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
        end else if (beat_q.size() != 0) begin
            if (!gap_done && $urandom_range(99) < idle_pct) begin
                // random idle burst before the next beat
                gap_left <= $urandom_range(10);
                gap_done <= 1'b1;
                start    <= 1'b0;
            end else begin
                cur_beat = beat_q.pop_front();
                i_kind          <= cur_beat.kind;
                i_stop_index    <= cur_beat.slot;
                i_stop_position <= cur_beat.pos;
                i_stop_red      <= cur_beat.rgba[0];
                i_stop_green    <= cur_beat.rgba[1];
                i_stop_blue     <= cur_beat.rgba[2];
                i_stop_alpha    <= cur_beat.rgba[3];
                i_sample_time   <= cur_beat.sample_t;
                start           <= 1'b1;
                gap_done        <= 1'b0;
            end
        end else begin
            start <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // monitor: every strobed color is matched against the oldest one
    // predicted, field by field
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_ramp_color want, got;
        if (i_rst_n && o_valid) begin
            got.rgba   = {o_out_alpha, o_out_blue, o_out_green, o_out_red};
            got.failed = o_failed;
            colors_seen++;
            if (color_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("color %0d: unexpected result rgba %h failed %b",
                             colors_seen, got.rgba, got.failed);
            end else begin
                want = color_expect_q.pop_front();
                for (int c = 0; c < 4; c++) begin
                    if (got.rgba[c] !== want.rgba[c]) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("color %0d: channel %0d expected %h got %h",
                                     colors_seen, c, want.rgba[c], got.rgba[c]);
                    end
                end
                if (got.failed !== want.failed) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("color %0d: failed expected %b got %b",
                                 colors_seen, want.failed, got.failed);
                end
            end
        end
    end

    // hard stop if the run hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("color_ramp_sample_unit regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic longint rand_span(input longint lo, input longint hi);
        longint unsigned r;
        r = {$urandom, $urandom};
        return lo + longint'(r % longint'(hi - lo + 1));
    endfunction

    function automatic longint clamp_pos(input longint p);
        if (p < POS_LO)
            return POS_LO;
        if (p > POS_HI)
            return POS_HI;
        return p;
    endfunction

    // channels lean toward the rails now and then
    function automatic t_rgba rand_rgba();
        t_rgba v;
        for (int c = 0; c < 4; c++) begin
            case ($urandom_range(7))
                0:       v[c] = '0;
                1:       v[c] = '1;
                default: v[c] = CHAN_W'($urandom_range(16'hFFFF));
            endcase
        end
        return v;
    endfunction

    task automatic push_load(input logic [INDEX_W-1:0] slot,
                             input logic signed [POS_W-1:0] pos, input t_rgba rgba);
        t_ramp_beat b;
        b.kind     = KIND_LOAD;
        b.slot     = slot;
        b.pos      = pos;
        b.rgba     = rgba;
        b.sample_t = $urandom;
        beat_q.push_back(b);
        plan_pos[slot]     = pos;
        plan_written[slot] = 1'b1;
        beats_made++;
    endtask

    // unused load fields carry noise on sample beats
    task automatic push_sample(input logic signed [POS_W-1:0] tq);
        t_ramp_beat b;
        b.kind     = KIND_SAMPLE;
        b.slot     = INDEX_W'($urandom_range(MAX_STOPS - 1));
        b.pos      = $urandom;
        b.rgba     = rand_rgba();
        b.sample_t = tq;
        beat_q.push_back(b);
        beats_made++;
    endtask

    // wait for the unit to go quiet: nothing queued, held or outstanding
    task automatic settle();
        while (beat_q.size() != 0 || start || color_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // stop_count only changes with the unit idle, which also makes the
    // sender pause until every predicted color has come out
    task automatic write_stop_count(input logic [COUNT_W-1:0] v);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        ramp_count = v;
    endtask

    // fill entries 0..n-1, mostly ascending with a chosen spacing scale
    task automatic load_table(input int n);
        longint p, step_max;
        bit     scrambled;
        int     mode;
        scrambled = ($urandom_range(9) == 0);
        mode      = $urandom_range(3);
        step_max  = (mode == 0) ? 64'sd134217728 : (mode == 1) ? 64'sd262144 : 64'sd7;
        p = rand_span(POS_LO, POS_HI - 16 * step_max);
        for (int i = 0; i < n; i++) begin
            if (scrambled) begin
                p = rand_span(POS_LO, POS_HI);
            end else if (i != 0) begin
                if (mode == 3) begin
                    case ($urandom_range(2))
                        0:       step_max = 64'sd7;
                        1:       step_max = 64'sd262144;
                        default: step_max = 64'sd134217728;
                    endcase
                end
                p = clamp_pos(p + rand_span(0, step_max));
            end
            push_load(INDEX_W'(i), POS_W'(p), rand_rgba());
        end
    endtask

    // sample times aimed inside segments, at stops, next to stops, or anywhere
    function automatic logic signed [POS_W-1:0] pick_time(input int n);
        int     r, i;
        longint lo, hi;
        r = $urandom_range(99);
        if (n == 0 || r >= 85) begin
            case ($urandom_range(4))
                0:       return POS_MIN;
                1:       return POS_MAX;
                default: return $urandom;
            endcase
        end
        if (r < 55 && n > 1) begin
            i  = $urandom_range(n - 1, 1);
            lo = plan_pos[i-1];
            hi = plan_pos[i];
            if (lo > hi) begin
                lo = plan_pos[i];
                hi = plan_pos[i-1];
            end
            return POS_W'(rand_span(lo, hi));
        end
        i = $urandom_range(n - 1);
        if (r < 70)
            return plan_pos[i];
        // one step either side, wraps at the rails
        return plan_pos[i] + (($urandom_range(1) == 0) ? -32'sd1 : 32'sd1);
    endfunction

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        int              n, r, slot;
        logic [COUNT_W-1:0] cnt;
        bit              ready, tail;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table at both time rails
        idle_pct = 25;
        write_stop_count(0);
        push_sample(POS_MIN);
        push_sample(POS_MAX);

        // two stops spanning the full position range, channels rising,
        // falling and flat
        push_load(0, POS_MIN, {16'hFFFF, 16'h1234, 16'hFFFF, 16'h0000});
        push_load(1, POS_MAX, {16'hFFFF, 16'h1234, 16'h0000, 16'hFFFF});
        write_stop_count(2);
        push_sample(POS_MIN);
        push_sample(POS_MAX);
        push_sample(32'sd0);
        push_sample(POS_MIN + 32'sd1);
        push_sample(POS_MAX - 32'sd1);
        push_sample(-32'sd1);

        // three stops: time landing exactly on the middle one, plus a load
        // to the top table entry
        push_load(1, 32'sd0, {16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF});
        push_load(2, POS_MAX, {16'h0001, 16'hFFFE, 16'h8001, 16'h0000});
        push_load(15, 32'sh0001_0000, rand_rgba());
        write_stop_count(3);
        push_sample(32'sd0);
        push_sample(32'sd1);
        push_sample(-32'sd1);
        push_sample(POS_MAX - 32'sd1);

        // single stop: every time gives its color
        write_stop_count(1);
        push_sample(POS_MIN);
        push_sample(POS_MAX);
        push_sample(32'sd12345);

        // random phases: new count, table fill, then a run of samples with
        // the odd stop reload; the tail keeps its count so nothing pauses
        while (beats_made < TOTAL_BEATS) begin
            tail = (beats_made > TOTAL_BEATS - 300);
            if (tail) begin
                cnt = ramp_count;
            end else begin
                r = $urandom_range(99);
                if (r < 5)
                    cnt = 0;
                else if (r < 10)
                    cnt = 1;
                else if (r < 20)
                    cnt = COUNT_W'($urandom_range(31, 17));
                else if (r < 35)
                    cnt = COUNT_W'(MAX_STOPS);
                else
                    cnt = COUNT_W'($urandom_range(15, 2));
                write_stop_count(cnt);
            end
            n = (cnt > MAX_STOPS) ? MAX_STOPS : int'(cnt);

            case ($urandom_range(3))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                2:       idle_pct = 35;
                default: idle_pct = 70;
            endcase
            if (tail)
                idle_pct = 0;

            // never sample a table with an unwritten live entry
            ready = 1'b1;
            for (int i = 0; i < n; i++)
                if (!plan_written[i])
                    ready = 1'b0;
            if (!ready || $urandom_range(2) == 0)
                load_table(n);

            repeat ($urandom_range(60, 20)) begin
                r = $urandom_range(99);
                if (r < 7 && n != 0) begin
                    // nudge a live stop, may break the ordering
                    slot = $urandom_range(n - 1);
                    push_load(INDEX_W'(slot),
                              POS_W'(clamp_pos(longint'(plan_pos[slot]) +
                                               rand_span(-65536, 65536))),
                              rand_rgba());
                end else if (r < 10 && n < MAX_STOPS) begin
                    // write beyond the live part of the table
                    push_load(INDEX_W'($urandom_range(MAX_STOPS - 1, n)), $urandom,
                              rand_rgba());
                end
                push_sample(pick_time(n));
            end
        end

        settle();
        if (mismatches == 0 && color_expect_q.size() == 0)
            $display("color_ramp_sample_unit regression: pass");
        else
            $display("color_ramp_sample_unit regression: fail");
        $finish;
    end

endmodule
